[src/pip_pkg.sv]
// Shared types for the point-in-polygon test block.
// Holds the operation codes and the control and status bundles of the edge unit.
// No dependencies.
package pip_pkg;

	typedef enum logic [1:0] {
		OP_WRITE_VERTEX = 2'd0,
		OP_SET_COUNT    = 2'd1,
		OP_QUERY        = 2'd2
	} op_t;

	typedef struct packed {
		logic clear;
		logic first;
		logic edge_en;
	} edge_ctrl_t;

	typedef struct packed {
		logic busy;
		logic parity;
	} edge_stat_t;

endpackage

[src/pip_vertex_mem.sv]
// Vertex store of the point-in-polygon test block.
// One write port and one registered read port; no reset of the contents.
// No package dependencies.
module pip_vertex_mem #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/pip_count_mem.sv]
// Polygon vertex count store of the point-in-polygon test block.
// A clearing pass after reset zeroes every entry, one per cycle; reads are registered.
// No package dependencies.
module pip_count_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 9,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	output logic              ready
);

	logic [WIDTH-1:0]  mem [DEPTH];
	logic [WIDTH-1:0]  rd_data_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (32'(clr_idx_q) == 32'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign ready   = !clearing_q;

endmodule

[src/pip_edge_unit.sv]
// Edge crossing pipeline of the point-in-polygon test block.
// Forms one edge per cycle from consecutive vertices, multiplies, compares and toggles parity.
// Depends on pip_pkg.
module pip_edge_unit import pip_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  edge_ctrl_t              ctrl,
	input  logic [2*COORD_BITS-1:0] vertex,
	input  logic [COORD_BITS-1:0]   px,
	input  logic [COORD_BITS-1:0]   py,
	output edge_stat_t              stat
);

	localparam int CB = COORD_BITS;

	logic signed [CB-1:0]     cur_x, cur_y, qx, qy;
	logic signed [CB-1:0]     prev_x_q, prev_y_q;
	logic signed [CB:0]       d_px_s1, d_y_s1, d_x_s1, d_py_s1;
	logic signed [2*CB+1:0]   lhs_s2, rhs_s2;
	logic                     dyneg_s2;
	logic                     valid_s1, valid_s2;
	logic                     straddle, hit;
	logic                     inside_q;

	assign cur_x = vertex[CB-1:0];
	assign cur_y = vertex[2*CB-1:CB];
	assign qx    = px;
	assign qy    = py;

	assign straddle = (cur_y > qy) != (prev_y_q > qy);
	assign hit      = dyneg_s2 ? (rhs_s2 < lhs_s2) : (lhs_s2 < rhs_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			valid_s1 <= ctrl.edge_en && straddle;
			valid_s2 <= valid_s1;
			if (ctrl.clear) begin
				inside_q <= 1'b0;
			end else if (valid_s2 && hit) begin
				inside_q <= !inside_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.first || ctrl.edge_en) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		d_px_s1  <= {qx[CB-1], qx} - {cur_x[CB-1], cur_x};
		d_y_s1   <= {prev_y_q[CB-1], prev_y_q} - {cur_y[CB-1], cur_y};
		d_x_s1   <= {prev_x_q[CB-1], prev_x_q} - {cur_x[CB-1], cur_x};
		d_py_s1  <= {qy[CB-1], qy} - {cur_y[CB-1], cur_y};
		lhs_s2   <= d_px_s1 * d_y_s1;
		rhs_s2   <= d_x_s1 * d_py_s1;
		dyneg_s2 <= d_y_s1[CB];
	end

	assign stat.busy   = valid_s1 || valid_s2;
	assign stat.parity = inside_q;

endmodule

[src/point_in_polygon_test.sv]
// Top level of the point-in-polygon test block: sequencer, memories and edge unit.
// Depends on pip_pkg, pip_vertex_mem, pip_count_mem and pip_edge_unit.
//
// Write-vertex and set-count items are taken in the idle state, which they do not leave. A
// query item first reads the polygon's count, then its last vertex to open the first edge,
// then every vertex in turn through the vertex memory's single read port, and the
// three-stage edge pipeline then drains for as long as crossings from the final edges
// are still in flight. A polygon with count zero or an out-of-range index skips the vertex
// walk. A query waits in its finish state only while an earlier result still sits unaccepted
// in the output register. After reset the count memory runs a clearing pass over all
// NUM_BASINS * NUM_BOUNDARIES entries before the first item is accepted. A result waits in
// an output register while further items are taken.
module point_in_polygon_test import pip_pkg::*; #(
	parameter int NUM_BASINS     = 8,
	parameter int NUM_BOUNDARIES = 4,
	parameter int MAX_VERTICES   = 256,
	parameter int COORD_BITS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [2:0]  basin_index,
	input  logic [1:0]  boundary_index,
	input  logic [7:0]  vertex_index,
	input  logic [8:0]  vertex_count,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        inside_res
);

	localparam int CB        = COORD_BITS;
	localparam int NUM_POLYS = NUM_BASINS * NUM_BOUNDARIES;
	localparam int VDEPTH    = NUM_POLYS * MAX_VERTICES;
	localparam int POLY_W    = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
	localparam int ADDR_W    = $clog2(VDEPTH);
	localparam int VIDX_W    = $clog2(MAX_VERTICES);
	localparam int CNT_W     = $clog2(MAX_VERTICES + 1);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_COUNT  = 6'b000100,
		ST_WALK   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   base_q;
	logic [CB-1:0]       px_q, py_q;
	logic [CNT_W-1:0]    n_q;
	logic [VIDX_W-1:0]   idx_q;
	logic                zero_q, first_q, edge_q;
	logic                out_valid_q, inside_res_q;

	logic                accept, poly_ok, vidx_ok, load_out;
	logic [POLY_W-1:0]   poly_idx;
	logic [CNT_W-1:0]    cnt_sat;
	logic                vtx_wr_en, vtx_rd_en, cnt_wr_en, cnt_rd_en, cnt_ready;
	logic [ADDR_W-1:0]   vtx_wr_addr, vtx_rd_addr;
	logic [2*CB-1:0]     vtx_rd_data;
	logic [CNT_W-1:0]    cnt_rdata;
	edge_ctrl_t          ectrl;
	edge_stat_t          estat;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign poly_ok  = (32'(basin_index) < 32'(NUM_BASINS)) &&
	                  (32'(boundary_index) < 32'(NUM_BOUNDARIES));
	assign vidx_ok  = 32'(vertex_index) < 32'(MAX_VERTICES);
	assign poly_idx = POLY_W'(32'(basin_index) * 32'(NUM_BOUNDARIES) + 32'(boundary_index));
	assign cnt_sat  = (32'(vertex_count) > 32'(MAX_VERTICES)) ?
	                  CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count);

	assign vtx_wr_en   = accept && (op_t'(opcode) == OP_WRITE_VERTEX) && poly_ok && vidx_ok;
	assign vtx_wr_addr = ADDR_W'(32'(poly_idx) * 32'(MAX_VERTICES) + 32'(vertex_index));
	assign cnt_wr_en   = accept && (op_t'(opcode) == OP_SET_COUNT) && poly_ok;
	assign cnt_rd_en   = accept && (op_t'(opcode) == OP_QUERY) && poly_ok;

	assign vtx_rd_en   = ((state_q == ST_COUNT) && (cnt_rdata != '0)) || (state_q == ST_WALK);
	assign vtx_rd_addr = (state_q == ST_COUNT) ?
	                     base_q + ADDR_W'(cnt_rdata - CNT_W'(1)) : base_q + ADDR_W'(idx_q);

	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	assign ectrl.clear   = accept && (op_t'(opcode) == OP_QUERY);
	assign ectrl.first   = first_q;
	assign ectrl.edge_en = edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			first_q     <= 1'b0;
			edge_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			first_q <= (state_q == ST_COUNT) && (cnt_rdata != '0);
			edge_q  <= (state_q == ST_WALK);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (op_t'(opcode) == OP_QUERY)) begin
						state_q <= poly_ok ? ST_COUNT : ST_FINISH;
					end
				end
				ST_COUNT: begin
					state_q <= (cnt_rdata == '0) ? ST_FINISH : ST_WALK;
				end
				ST_WALK: begin
					if (32'(idx_q) + 32'd1 == 32'(n_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!first_q && !edge_q && !estat.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op_t'(opcode) == OP_QUERY)) begin
			px_q   <= coord_x[CB-1:0];
			py_q   <= coord_y[CB-1:0];
			base_q <= ADDR_W'(32'(poly_idx) * 32'(MAX_VERTICES));
			zero_q <= !poly_ok;
		end
		if (state_q == ST_COUNT) begin
			n_q   <= cnt_rdata;
			idx_q <= '0;
			if (cnt_rdata == '0) begin
				zero_q <= 1'b1;
			end
		end else if (state_q == ST_WALK) begin
			idx_q <= idx_q + 1'b1;
		end
		if (load_out) begin
			inside_res_q <= zero_q ? 1'b0 : estat.parity;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_res_q;

	pip_vertex_mem #(
		.DEPTH (VDEPTH),
		.WIDTH (2 * CB)
	) u_vertex_mem (
		.clk     (clk),
		.wr_en   (vtx_wr_en),
		.wr_addr (vtx_wr_addr),
		.wr_data ({coord_y[CB-1:0], coord_x[CB-1:0]}),
		.rd_en   (vtx_rd_en),
		.rd_addr (vtx_rd_addr),
		.rd_data (vtx_rd_data)
	);

	pip_count_mem #(
		.DEPTH (NUM_POLYS),
		.WIDTH (CNT_W)
	) u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cnt_wr_en),
		.wr_addr (poly_idx),
		.wr_data (cnt_sat),
		.rd_en   (cnt_rd_en),
		.rd_addr (poly_idx),
		.rd_data (cnt_rdata),
		.ready   (cnt_ready)
	);

	pip_edge_unit #(
		.COORD_BITS (CB)
	) u_edge_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ectrl),
		.vertex (vtx_rd_data),
		.px     (px_q),
		.py     (py_q),
		.stat   (estat)
	);

	a_finish_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!estat.busy && !first_q && !edge_q))
		else $error("Query finished while edges were still in flight.");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (32'(idx_q) < 32'(n_q)))
		else $error("Vertex walk ran past the polygon's count.");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_wr_en |-> !vtx_rd_en)
		else $error("Vertex write overlapped a query read.");

	a_query_reads_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_rd_en |=> (state_q == ST_COUNT))
		else $error("Count read was issued without entering the count state.");

endmodule

[tb/sv/tb_point_in_polygon_test.sv]
`timescale 1ns / 100ps
// Testbench for point_in_polygon_test: loads polygons, sets their vertex counts and queries
// points, checking each inside bit against a crossing-parity predictor held here.
// Depends on pip_pkg and point_in_polygon_test.
module tb_point_in_polygon_test;
	import pip_pkg::*;

	localparam int NUM_BASINS = 8;
	localparam int NUM_BOUNDARIES = 4;
	localparam int MAX_VERTICES = 256;
	localparam int NUM_POLYS = NUM_BASINS * NUM_BOUNDARIES;
	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam logic [31:0] C_MIN = 32'h8000_0000;
	localparam logic [31:0] C_MAX = 32'h7fff_ffff;
	localparam longint COORD_LO = -(longint'(1) << 31);
	localparam longint COORD_HI = (longint'(1) << 31) - 1;
	localparam int RANDOM_ITEMS = 1825;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES = 1000;
	localparam int SEND_IDLE [4] = '{0, 54, 0, 22};
	localparam int RECV_STALL [4] = '{0, 0, 54, 22};

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  basin;
		logic [1:0]  bnd;
		logic [7:0]  vidx;
		logic [8:0]  cnt;
		logic [31:0] x;
		logic [31:0] y;
	} pip_item_t;

	typedef struct packed {
		pip_item_t item;
		bit        has_res;
		bit        res;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = '0;
	logic [2:0]  basin_index = '0;
	logic [1:0]  boundary_index = '0;
	logic [7:0]  vertex_index = '0;
	logic [8:0]  vertex_count = '0;
	logic [31:0] coord_x = '0;
	logic [31:0] coord_y = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        inside_res;

	logic [63:0] vtx_mem [NUM_POLYS * MAX_VERTICES];
	bit          slot_written [NUM_POLYS * MAX_VERTICES];
	logic [8:0]  poly_count [NUM_POLYS] = '{default: '0};
	longint      shape_cx [NUM_POLYS] = '{default: 0};
	longint      shape_cy [NUM_POLYS] = '{default: 0};
	longint      shape_span [NUM_POLYS] = '{default: 1048576};
	bit          pending_inside [$];

	directed_row_t directed_table [25];
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_request = 1'b0;
	int  cycle_count = 0;
	int  items_sent = 0;
	int  queries_sent = 0;
	int  results_checked = 0;
	int  mismatches = 0;
	bit  want;

	point_in_polygon_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.basin_index(basin_index),
		.boundary_index(boundary_index),
		.vertex_index(vertex_index),
		.vertex_count(vertex_count),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.inside_res(inside_res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit crossing_parity(int p, logic [31:0] qx, logic [31:0] qy);
		longint px, py, xi, yi, xj, yj, dy;
		logic signed [127:0] lhs, rhs, fa, fb;
		int n, j, base;
		bit parity;
		px = longint'($signed(qx));
		py = longint'($signed(qy));
		n = int'(poly_count[p]);
		base = p * MAX_VERTICES;
		parity = 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = longint'($signed(vtx_mem[base + i][31:0]));
			yi = longint'($signed(vtx_mem[base + i][63:32]));
			xj = longint'($signed(vtx_mem[base + j][31:0]));
			yj = longint'($signed(vtx_mem[base + j][63:32]));
			if ((yi > py) != (yj > py)) begin
				dy = yj - yi;
				fa = px - xi;
				fb = dy;
				lhs = fa * fb;
				fa = xj - xi;
				fb = py - yi;
				rhs = fa * fb;
				if (dy > 0 ? lhs < rhs : rhs < lhs)
					parity = !parity;
			end
			j = i;
		end
		return parity;
	endfunction

	function automatic void predict_item(pip_item_t it, bit has_res, bit res);
		int p, addr;
		p = it.basin * NUM_BOUNDARIES + it.bnd;
		addr = p * MAX_VERTICES + it.vidx;
		case (it.op)
			OP_WRITE_VERTEX: begin
				vtx_mem[addr] = {it.y, it.x};
				slot_written[addr] = 1'b1;
			end
			OP_SET_COUNT: begin
				poly_count[p] = (it.cnt > MAX_VERTICES) ? 9'(MAX_VERTICES) : it.cnt;
			end
			OP_QUERY: begin
				pending_inside.push_back(has_res ? res : crossing_parity(p, it.x, it.y));
				queries_sent++;
			end
			default: ;
		endcase
		if (it.op != OP_RESERVED)
			items_sent++;
	endfunction

	function automatic bit poly_readable(int p);
		for (int i = 0; i < poly_count[p]; i++)
			if (!slot_written[p * MAX_VERTICES + i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int pick_readable();
		int start;
		start = $urandom_range(NUM_POLYS - 1);
		for (int k = 0; k < NUM_POLYS; k++)
			if (poly_readable((start + k) % NUM_POLYS))
				return (start + k) % NUM_POLYS;
		return -1;
	endfunction

	function automatic logic [31:0] near_coord(longint c, longint span);
		longint unsigned r;
		longint v;
		r = {$urandom, $urandom};
		v = c + longint'(r % longint'(2 * span + 1)) - span;
		if (v < COORD_LO)
			v = COORD_LO;
		if (v > COORD_HI)
			v = COORD_HI;
		return v[31:0];
	endfunction

	function automatic longint pick_center();
		case ($urandom_range(3))
			0: return 0;
			1: return $urandom_range(1) ? COORD_LO : COORD_HI;
			default: return longint'($signed($urandom));
		endcase
	endfunction

	function automatic pip_item_t make_item(logic [1:0] op, int p, logic [7:0] vidx,
			logic [8:0] cnt, logic [31:0] x, logic [31:0] y);
		pip_item_t it;
		it.op = op;
		it.basin = 3'(p / NUM_BOUNDARIES);
		it.bnd = 2'(p % NUM_BOUNDARIES);
		it.vidx = vidx;
		it.cnt = cnt;
		it.x = x;
		it.y = y;
		return it;
	endfunction

	task automatic send(input pip_item_t it, input bit has_res, input bit res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= it.op;
		basin_index <= it.basin;
		boundary_index <= it.bnd;
		vertex_index <= it.vidx;
		vertex_count <= it.cnt;
		coord_x <= it.x;
		coord_y <= it.y;
		do @(posedge clk); while (!in_ready);
		predict_item(it, has_res, res);
	endtask

	task automatic query_at(input int p);
		int n, v;
		logic [31:0] qx, qy;
		n = int'(poly_count[p]);
		v = p * MAX_VERTICES + ((n > 0) ? $urandom_range(n - 1) : 0);
		qx = near_coord(shape_cx[p], shape_span[p] + shape_span[p] / 4);
		qy = near_coord(shape_cy[p], shape_span[p] + shape_span[p] / 4);
		case ($urandom_range(9))
			0: begin
				qx = $urandom;
				qy = $urandom;
			end
			1: if (n > 0) begin
				qx = vtx_mem[v][31:0];
				qy = vtx_mem[v][63:32];
			end
			2: if (n > 0) qy = vtx_mem[v][63:32];
			3: if (n > 0) qx = vtx_mem[v][31:0];
			default: ;
		endcase
		send(make_item(OP_QUERY, p, 8'($urandom_range(255)), 9'($urandom_range(511)), qx, qy),
			1'b0, 1'b0);
	endtask

	task automatic noise_item();
		int p;
		p = $urandom_range(NUM_POLYS - 1);
		case ($urandom_range(3))
			0: send(make_item(OP_RESERVED, p, 8'($urandom_range(255)),
				9'($urandom_range(511)), $urandom, $urandom), 1'b0, 1'b0);
			1: send(make_item(OP_WRITE_VERTEX, p, 8'($urandom_range(255)),
				9'($urandom_range(511)), $urandom, $urandom), 1'b0, 1'b0);
			2: send(make_item(OP_SET_COUNT, p, 8'($urandom_range(255)),
				9'($urandom_range(511)), $urandom, $urandom), 1'b0, 1'b0);
			default: begin
				p = pick_readable();
				if (p >= 0)
					query_at(p);
			end
		endcase
	endtask

	task automatic polygon_sequence(input int p, input int n, input int count_val,
			input int queries);
		longint prev_y;
		logic [31:0] vx, vy;
		shape_cx[p] = pick_center();
		shape_cy[p] = pick_center();
		shape_span[p] = longint'(1) << $urandom_range(3, 31);
		prev_y = shape_cy[p];
		for (int i = 0; i < n; i++) begin
			vx = near_coord(shape_cx[p], shape_span[p]);
			vy = ($urandom_range(4) == 0) ? prev_y[31:0] : near_coord(shape_cy[p], shape_span[p]);
			prev_y = longint'($signed(vy));
			send(make_item(OP_WRITE_VERTEX, p, 8'(i), 9'($urandom_range(511)), vx, vy),
				1'b0, 1'b0);
			if ($urandom_range(19) == 0)
				noise_item();
		end
		send(make_item(OP_SET_COUNT, p, 8'($urandom_range(255)), 9'(count_val), $urandom,
			$urandom), 1'b0, 1'b0);
		if (poly_readable(p))
			for (int k = 0; k < queries; k++)
				query_at(p);
	endtask

	initial begin : stimulus
		int r, s, p, n, cnt, phase_end;
		directed_table = '{
			'{'{OP_QUERY, 3'd0, 2'd0, 8'd0, 9'd0, 32'd0, 32'd0}, 1'b1, 1'b0},
			'{'{OP_QUERY, 3'd7, 2'd3, 8'hff, 9'h1ff, C_MAX, C_MIN}, 1'b1, 1'b0},
			'{'{OP_RESERVED, 3'd7, 2'd3, 8'hff, 9'h1ff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, 1'b0},
			'{'{OP_WRITE_VERTEX, 3'd1, 2'd2, 8'd0, 9'd0, C_MIN, C_MIN}, 1'b0, 1'b0},
			'{'{OP_WRITE_VERTEX, 3'd1, 2'd2, 8'd1, 9'h1ff, C_MAX, C_MIN}, 1'b0, 1'b0},
			'{'{OP_WRITE_VERTEX, 3'd1, 2'd2, 8'd2, 9'd0, C_MAX, C_MAX}, 1'b0, 1'b0},
			'{'{OP_WRITE_VERTEX, 3'd1, 2'd2, 8'd3, 9'd0, C_MIN, C_MAX}, 1'b0, 1'b0},
			'{'{OP_SET_COUNT, 3'd1, 2'd2, 8'd0, 9'd4, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd1, 2'd2, 8'd0, 9'd0, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd1, 2'd2, 8'd0, 9'd0, C_MIN, C_MIN}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd1, 2'd2, 8'd0, 9'd0, C_MAX, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd1, 2'd2, 8'd0, 9'd0, C_MIN, 32'd0}, 1'b0, 1'b0},
			'{'{OP_WRITE_VERTEX, 3'd5, 2'd0, 8'd0, 9'd0, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_WRITE_VERTEX, 3'd5, 2'd0, 8'd1, 9'd0, 32'h0080_0000, 32'd0}, 1'b0, 1'b0},
			'{'{OP_WRITE_VERTEX, 3'd5, 2'd0, 8'd2, 9'd0, 32'd0, 32'h0080_0000}, 1'b0, 1'b0},
			'{'{OP_SET_COUNT, 3'd5, 2'd0, 8'd0, 9'd3, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd5, 2'd0, 8'd0, 9'd0, 32'hff80_0000, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd5, 2'd0, 8'd0, 9'd0, 32'h0020_0000, 32'h0020_0000}, 1'b0, 1'b0},
			'{'{OP_SET_COUNT, 3'd5, 2'd0, 8'd0, 9'd1, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd5, 2'd0, 8'd0, 9'd0, 32'hff80_0000, 32'd0}, 1'b0, 1'b0},
			'{'{OP_SET_COUNT, 3'd5, 2'd0, 8'd0, 9'd2, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd5, 2'd0, 8'd0, 9'd0, 32'h0040_0000, 32'd0}, 1'b0, 1'b0},
			'{'{OP_SET_COUNT, 3'd0, 2'd1, 8'd0, 9'h1ff, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_SET_COUNT, 3'd0, 2'd1, 8'd0, 9'd0, 32'd0, 32'd0}, 1'b0, 1'b0},
			'{'{OP_QUERY, 3'd0, 2'd1, 8'd0, 9'd0, 32'd0, 32'd0}, 1'b1, 1'b0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_table[k])
			send(directed_table[k].item, directed_table[k].has_res, directed_table[k].res);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_inside.size() != 0) @(posedge clk);

		phase_end = items_sent;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			phase_end += RANDOM_ITEMS / 4;
			if (ph == 0 || ph == 3)
				polygon_sequence($urandom_range(NUM_POLYS - 1), MAX_VERTICES,
					$urandom_range(256, 511), 4);
			if (ph == 0) begin
				// Long output stall while queries keep coming, so the block backs up.
				hold_request = 1'b1;
				for (int k = 0; k < 12; k++) begin
					p = pick_readable();
					if (p >= 0)
						query_at(p);
				end
			end
			while (items_sent < phase_end) begin
				r = $urandom_range(99);
				if (r < 70) begin
					p = $urandom_range(NUM_POLYS - 1);
					s = $urandom_range(99);
					n = (s < 5) ? $urandom_range(2) :
						(s < 85) ? $urandom_range(3, 12) : $urandom_range(13, 48);
					cnt = ($urandom_range(19) == 0) ? n + $urandom_range(1, 8) : n;
					polygon_sequence(p, n, cnt, $urandom_range(2, 7));
				end else begin
					repeat ($urandom_range(1, 4)) noise_item();
				end
			end
			in_valid <= 1'b0;
			@(posedge clk);
			while (pending_inside.size() != 0) @(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d items (%0d queries), %0d results checked, %0d mismatches",
			items_sent, queries_sent, results_checked, mismatches);
		$display("summary: four idle/stall patterns, one long output hold, two full polygons");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : receiver
		int held;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_inside.size() == 0) begin
				if (mismatches < 10)
					$display("cycle %0d: unexpected result inside_res=%0b with none pending",
						cycle_count, inside_res);
				mismatches++;
			end else begin
				want = pending_inside.pop_front();
				if (inside_res !== want) begin
					if (mismatches < 10)
						$display("cycle %0d: inside_res expected %0b, got %0b",
							cycle_count, want, inside_res);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, pending_inside.size());
			$display("tb: failure");
			$finish;
		end
	end

endmodule

[point_in_polygon_test.f]
src/pip_pkg.sv
src/pip_vertex_mem.sv
src/pip_count_mem.sv
src/pip_edge_unit.sv
src/point_in_polygon_test.sv
tb/sv/tb_point_in_polygon_test.sv
